// File: rtl/core/puv_pkg.sv
// Shared types, constants and helpers of the planar UV projection core.
`default_nettype none
package puv_pkg;

  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int POS_W         = 32;
  localparam int TRIG_W        = 16;
  localparam int TEX_W         = 20;
  localparam int DIFF_W        = POS_W + 1;
  localparam int DIV_W         = 32;
  localparam int FRAC_W        = 16;
  localparam int NUM_W         = DIFF_W + FRAC_W;
  localparam int QUOT_W        = 32;
  localparam int ROT_W         = 51;
  localparam int BACK_LAT      = NUM_W + 5;
  localparam int QUEUE_DEPTH   = 4;
  localparam int SETTLE_CYCLES = 3;

  localparam logic [DIV_W-1:0]         ONE_Q16   = 32'd65536;
  localparam logic signed [DIFF_W-1:0] HALF_Q16  = 33'sd32768;
  localparam logic signed [ROT_W-1:0]  HALF_ROT  = 51'sd32768;
  localparam logic signed [ROT_W-1:0]  ROUND_Q14 = 51'sd8192;
  localparam logic signed [ROT_W-1:0]  OUT_MAX   = 51'sd524287;
  localparam logic signed [ROT_W-1:0]  OUT_MIN   = -51'sd524288;
  localparam logic signed [TRIG_W-1:0] COS_RESET = 16'sd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X, REG_MIN_Y, REG_MIN_Z,
    REG_MAX_X, REG_MAX_Y, REG_MAX_Z,
    REG_COS, REG_SIN
  } cfg_reg_e;

  typedef enum logic [1:0] {PLANE_XY, PLANE_XZ, PLANE_YZ} plane_e;

  typedef struct packed {
    logic signed [DIFF_W-1:0] diff_u;
    logic signed [DIFF_W-1:0] diff_v;
    logic [DIV_W-1:0]         div_u;
    logic [DIV_W-1:0]         div_v;
  } work_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } rot_t;

  function automatic logic signed [TEX_W-1:0] sat_tex(input logic signed [ROT_W-1:0] x);
    logic signed [TEX_W-1:0] r;
    if (x > OUT_MAX) begin
      r = OUT_MAX[TEX_W-1:0];
    end else if (x < OUT_MIN) begin
      r = OUT_MIN[TEX_W-1:0];
    end else begin
      r = x[TEX_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/puv_if.sv
// Handshake channel interfaces: vertex input, texture output and configuration writes.
`default_nettype none
interface puv_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [puv_pkg::POS_W-1:0]    pos_x;
  logic signed [puv_pkg::POS_W-1:0]    pos_y;
  logic signed [puv_pkg::POS_W-1:0]    pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface puv_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [puv_pkg::TEX_W-1:0]    tex_u;
  logic signed [puv_pkg::TEX_W-1:0]    tex_v;
  modport source (output valid, tex_u, tex_v, input ready);
  modport sink (input valid, tex_u, tex_v, output ready);
endinterface

interface puv_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [puv_pkg::CFG_IDX_W-1:0]       index;
  logic [puv_pkg::CFG_DATA_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/planar_uv_projection_core.sv
// Throughput: one vertex per cycle while the output is not stalled and no configuration
// write is settling, set by the one-bit-per-stage divider pipelines.
// A configuration write holds off vertex input while plane selection settles.
// Reset clears the queue and pipeline and sets the configuration registers to reset values.
`default_nettype none
module planar_uv_projection_core #(
  parameter int QueueDepth = puv_pkg::QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  puv_cfg_if.sink   cfg_i,
  puv_in_if.sink    vtx_i,
  puv_out_if.source tex_o
);

  logic push, full, q_valid, pop;
  puv_pkg::work_t push_data, q_data;
  puv_pkg::rot_t rot;

  puv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .vtx_i       (vtx_i),
    .q_full_i    (full),
    .push_o      (push),
    .push_data_o (push_data),
    .rot_o       (rot)
  );

  puv_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (pop)
  );

  puv_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (pop),
    .rot_i     (rot),
    .tex_o     (tex_o)
  );

endmodule
`default_nettype wire

// File: rtl/core/puv_front.sv
// Front end: configuration registers, plane selection and per-item operand setup.
`default_nettype none
module puv_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  puv_cfg_if.sink             cfg_i,
  puv_in_if.sink              vtx_i,
  input  wire logic           q_full_i,
  output logic                push_o,
  output puv_pkg::work_t      push_data_o,
  output puv_pkg::rot_t       rot_o
);

  logic signed [puv_pkg::POS_W-1:0] min_x_q, min_y_q, min_z_q;
  logic signed [puv_pkg::POS_W-1:0] max_x_q, max_y_q, max_z_q;
  logic signed [puv_pkg::TRIG_W-1:0] cos_q, sin_q;
  logic [1:0] settle_q;
  logic [puv_pkg::DIV_W-1:0] ax_q, ay_q, az_q;
  logic [2*puv_pkg::DIV_W-1:0] axy_q, axz_q, ayz_q;
  puv_pkg::plane_e plane_q, plane_d;
  logic cfg_wr;

  logic signed [puv_pkg::DIFF_W-1:0] szx, szy, szz;
  logic [puv_pkg::DIV_W-1:0] divx, divy, divz;
  logic signed [puv_pkg::DIFF_W-1:0] dx, dy, dz;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= '0; min_y_q <= '0; min_z_q <= '0;
      max_x_q <= '0; max_y_q <= '0; max_z_q <= '0;
      cos_q <= puv_pkg::COS_RESET;
      sin_q <= '0;
    end else if (cfg_wr) begin
      case (puv_pkg::cfg_reg_e'(cfg_i.index))
        puv_pkg::REG_MIN_X: min_x_q <= cfg_i.data[puv_pkg::POS_W-1:0];
        puv_pkg::REG_MIN_Y: min_y_q <= cfg_i.data[puv_pkg::POS_W-1:0];
        puv_pkg::REG_MIN_Z: min_z_q <= cfg_i.data[puv_pkg::POS_W-1:0];
        puv_pkg::REG_MAX_X: max_x_q <= cfg_i.data[puv_pkg::POS_W-1:0];
        puv_pkg::REG_MAX_Y: max_y_q <= cfg_i.data[puv_pkg::POS_W-1:0];
        puv_pkg::REG_MAX_Z: max_z_q <= cfg_i.data[puv_pkg::POS_W-1:0];
        puv_pkg::REG_COS:   cos_q <= cfg_i.data[puv_pkg::TRIG_W-1:0];
        puv_pkg::REG_SIN:   sin_q <= cfg_i.data[puv_pkg::TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // Box sizes, plane areas and the plane choice settle in turn after reset or
  // any write; input is held off until then.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 2'(puv_pkg::SETTLE_CYCLES);
    end else if (cfg_wr) begin
      settle_q <= 2'(puv_pkg::SETTLE_CYCLES);
    end else if (settle_q != 2'd0) begin
      settle_q <= settle_q - 2'd1;
    end
  end

  assign szx = {max_x_q[31], max_x_q} - {min_x_q[31], min_x_q};
  assign szy = {max_y_q[31], max_y_q} - {min_y_q[31], min_y_q};
  assign szz = {max_z_q[31], max_z_q} - {min_z_q[31], min_z_q};

  always_comb begin
    if (axz_q >= axy_q && axz_q >= ayz_q) begin
      plane_d = puv_pkg::PLANE_XZ;
    end else if (ayz_q >= axy_q && ayz_q >= axz_q) begin
      plane_d = puv_pkg::PLANE_YZ;
    end else begin
      plane_d = puv_pkg::PLANE_XY;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q  <= szx[32] ? '0 : szx[31:0];
    ay_q  <= szy[32] ? '0 : szy[31:0];
    az_q  <= szz[32] ? '0 : szz[31:0];
    axy_q <= ax_q * ay_q;
    axz_q <= ax_q * az_q;
    ayz_q <= ay_q * az_q;
    plane_q <= plane_d;
  end

  // An empty or inverted axis divides by 1.0.
  assign divx = (ax_q == '0) ? puv_pkg::ONE_Q16 : ax_q;
  assign divy = (ay_q == '0) ? puv_pkg::ONE_Q16 : ay_q;
  assign divz = (az_q == '0) ? puv_pkg::ONE_Q16 : az_q;

  assign dx = {vtx_i.pos_x[31], vtx_i.pos_x} - {min_x_q[31], min_x_q};
  assign dy = {vtx_i.pos_y[31], vtx_i.pos_y} - {min_y_q[31], min_y_q};
  assign dz = {vtx_i.pos_z[31], vtx_i.pos_z} - {min_z_q[31], min_z_q};

  always_comb begin
    case (plane_q)
      puv_pkg::PLANE_XZ: push_data_o = '{diff_u: dx, diff_v: dz, div_u: divx, div_v: divz};
      puv_pkg::PLANE_YZ: push_data_o = '{diff_u: dy, diff_v: dz, div_u: divy, div_v: divz};
      default:           push_data_o = '{diff_u: dx, diff_v: dy, div_u: divx, div_v: divy};
    endcase
  end

  assign vtx_i.ready = (settle_q == 2'd0) && !q_full_i;
  assign push_o      = vtx_i.valid && vtx_i.ready;
  assign rot_o       = '{cos_v: cos_q, sin_v: sin_q};

  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> !vtx_i.ready)
    else $error("item accepted while plane selection settles");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_full_i)
    else $error("push into a full queue");

endmodule
`default_nettype wire

// File: rtl/core/puv_fifo.sv
// Short queue of prepared items between the front end and the divider pipeline.
`default_nettype none
module puv_fifo #(
  parameter int Depth = puv_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  puv_pkg::work_t      data_i,
  output logic                full_o,
  output logic                valid_o,
  output puv_pkg::work_t      data_o,
  input  wire logic           pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  puv_pkg::work_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from an empty queue");

endmodule
`default_nettype wire

// File: rtl/core/puv_div.sv
// Pipelined restoring divider: one quotient bit per stage, saturated to 32 bits.
`default_nettype none
module puv_div (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic signed [puv_pkg::DIFF_W-1:0]   diff_i,
  input  wire logic [puv_pkg::DIV_W-1:0]           divisor_i,
  output logic signed [puv_pkg::QUOT_W-1:0]        quot_o
);

  localparam int NB = puv_pkg::NUM_W;
  localparam int DW = puv_pkg::DIV_W;

  logic [NB-1:0] num_q [NB+1];
  logic [NB-1:0] quo_q [NB+1];
  logic [DW-1:0] rem_q [NB+1];
  logic [DW-1:0] dvs_q [NB+1];
  logic          neg_q [NB+1];
  logic [puv_pkg::DIFF_W-1:0] mag;
  logic [NB-1:0] qf;
  logic signed [puv_pkg::QUOT_W-1:0] quot_q;

  assign mag = diff_i[puv_pkg::DIFF_W-1] ? -diff_i : diff_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0] <= diff_i[puv_pkg::DIFF_W-1];
      num_q[0] <= {mag, {puv_pkg::FRAC_W{1'b0}}};
      quo_q[0] <= '0;
      rem_q[0] <= '0;
      dvs_q[0] <= divisor_i;
    end
  end

  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic [DW+1:0] trial;
    logic [DW:0]   shifted;
    assign shifted = {rem_q[k], num_q[k][NB-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[k+1] <= neg_q[k];
        dvs_q[k+1] <= dvs_q[k];
        num_q[k+1] <= {num_q[k][NB-2:0], 1'b0};
        quo_q[k+1] <= {quo_q[k][NB-2:0], !trial[DW+1]};
        rem_q[k+1] <= trial[DW+1] ? shifted[DW-1:0] : trial[DW-1:0];
      end
    end
  end

  assign qf = quo_q[NB];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!neg_q[NB]) begin
        quot_q <= (|qf[NB-1:31]) ? 32'sh7FFF_FFFF : qf[31:0];
      end else if ((|qf[NB-1:32]) || (qf[31] && (|qf[30:0]))) begin
        quot_q <= 32'sh8000_0000;
      end else begin
        quot_q <= -qf[31:0];
      end
    end
  end

  assign quot_o = quot_q;

endmodule
`default_nettype wire

// File: rtl/core/puv_back.sv
// Back end: two divider pipelines, rotation about the texture center and the output stage.
`default_nettype none
module puv_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  input  puv_pkg::work_t      q_data_i,
  output logic                q_pop_o,
  input  puv_pkg::rot_t       rot_i,
  puv_out_if.source           tex_o
);

  localparam int Lat = puv_pkg::BACK_LAT;

  logic adv;
  logic [Lat-1:0] vld_q;
  logic signed [puv_pkg::QUOT_W-1:0] qu, qv;
  logic signed [puv_pkg::DIFF_W-1:0] du_q, dv_q;
  logic signed [puv_pkg::TRIG_W-1:0] c_s, s_s;
  logic signed [puv_pkg::DIFF_W+puv_pkg::TRIG_W-1:0] puc_q, pvs_q, pus_q, pvc_q;
  logic signed [puv_pkg::ROT_W-1:0] ru, rv, ru_sh, rv_sh;
  logic signed [puv_pkg::TEX_W-1:0] u_q, v_q;

  // The whole pipeline moves together whenever the output slot can take an item.
  assign adv     = !vld_q[Lat-1] || tex_o.ready;
  assign q_pop_o = adv && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], q_valid_i};
    end
  end

  puv_div u_div_u (
    .clk_i     (clk_i),
    .en_i      (adv),
    .diff_i    (q_data_i.diff_u),
    .divisor_i (q_data_i.div_u),
    .quot_o    (qu)
  );

  puv_div u_div_v (
    .clk_i     (clk_i),
    .en_i      (adv),
    .diff_i    (q_data_i.diff_v),
    .divisor_i (q_data_i.div_v),
    .quot_o    (qv)
  );

  assign c_s = $signed(rot_i.cos_v);
  assign s_s = $signed(rot_i.sin_v);

  assign ru = puv_pkg::ROT_W'(puc_q) - puv_pkg::ROT_W'(pvs_q) + puv_pkg::ROUND_Q14;
  assign rv = puv_pkg::ROT_W'(pus_q) + puv_pkg::ROT_W'(pvc_q) + puv_pkg::ROUND_Q14;
  assign ru_sh = (ru >>> 14) + puv_pkg::HALF_ROT;
  assign rv_sh = (rv >>> 14) + puv_pkg::HALF_ROT;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      du_q  <= {qu[31], qu} - puv_pkg::HALF_Q16;
      dv_q  <= {qv[31], qv} - puv_pkg::HALF_Q16;
      puc_q <= du_q * c_s;
      pvs_q <= dv_q * s_s;
      pus_q <= du_q * s_s;
      pvc_q <= dv_q * c_s;
      u_q   <= puv_pkg::sat_tex(ru_sh);
      v_q   <= puv_pkg::sat_tex(rv_sh);
    end
  end

  assign tex_o.valid = vld_q[Lat-1];
  assign tex_o.tex_u = u_q;
  assign tex_o.tex_v = v_q;

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline moved while the output stalled");

  a_pop_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> vld_q[0])
    else $error("popped item lost at pipeline entry");

endmodule
`default_nettype wire

// File: tb/planar_uv_projection_core_checker.sv
// Checker for the planar UV core: register mirror, projection predictor and result compare.
module planar_uv_projection_core_checker (
  input  logic clk_i,
  input  logic rst_ni,
  puv_cfg_if   cfg,
  puv_in_if    vtx,
  puv_out_if   tex,
  output int   errors_o
);

  typedef struct {
    logic signed [puv_pkg::TEX_W-1:0] u;
    logic signed [puv_pkg::TEX_W-1:0] v;
  } uv_t;

  logic signed [puv_pkg::POS_W-1:0]  box_lo [3];
  logic signed [puv_pkg::POS_W-1:0]  box_hi [3];
  logic signed [puv_pkg::TRIG_W-1:0] rot_cos;
  logic signed [puv_pkg::TRIG_W-1:0] rot_sin;
  uv_t                               uv_pending[$];
  int                                n_checked;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch after %0d results: %s", $realtime, n_checked, what);
    errors_o++;
  endtask

  // Truncating division toward zero, then clamp to the signed 32-bit range.
  function automatic longint norm_axis(input longint p, input longint lo, input longint sz);
    longint div;
    longint q;
    div = (sz > 0) ? sz : 64'sd65536;
    q = ((p - lo) * 64'sd65536) / div;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  function automatic logic signed [puv_pkg::TEX_W-1:0] clamp_tex(input longint x);
    if (x > 64'sd524287) return 20'sd262143 * 2 + 1;
    if (x < -64'sd524288) return -20'sd524288;
    return x[puv_pkg::TEX_W-1:0];
  endfunction

  function automatic uv_t project_vertex(input logic signed [puv_pkg::POS_W-1:0] px,
                                         input logic signed [puv_pkg::POS_W-1:0] py,
                                         input logic signed [puv_pkg::POS_W-1:0] pz);
    longint          lo [3];
    longint          sz [3];
    longint          p [3];
    bit [63:0]       area [3];
    bit [63:0]       a_xy, a_xz, a_yz;
    puv_pkg::plane_e plane;
    int              iu, iv;
    longint          du, dv, ru, rv, c, s;
    uv_t             r;
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    for (int k = 0; k < 3; k++) begin
      lo[k] = box_lo[k];
      sz[k] = longint'(box_hi[k]) - lo[k];
      area[k] = (sz[k] > 0) ? 64'(sz[k]) : 64'd0;
    end
    a_xy = area[0] * area[1];
    a_xz = area[0] * area[2];
    a_yz = area[1] * area[2];
    if (a_xz >= a_xy && a_xz >= a_yz) plane = puv_pkg::PLANE_XZ;
    else if (a_yz >= a_xy) plane = puv_pkg::PLANE_YZ;
    else plane = puv_pkg::PLANE_XY;
    case (plane)
      puv_pkg::PLANE_XZ: begin iu = 0; iv = 2; end
      puv_pkg::PLANE_YZ: begin iu = 1; iv = 2; end
      default:           begin iu = 0; iv = 1; end
    endcase
    c = rot_cos;
    s = rot_sin;
    du = norm_axis(p[iu], lo[iu], sz[iu]) - 32768;
    dv = norm_axis(p[iv], lo[iv], sz[iv]) - 32768;
    ru = ((du * c - dv * s + 8192) >>> 14) + 32768;
    rv = ((du * s + dv * c + 8192) >>> 14) + 32768;
    r.u = clamp_tex(ru);
    r.v = clamp_tex(rv);
    return r;
  endfunction

  // Signals are read in the active region of the edge, before any flop updates.
  always @(posedge clk_i or negedge rst_ni) begin
    uv_t want;
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        box_lo[k] = '0;
        box_hi[k] = '0;
      end
      rot_cos = puv_pkg::COS_RESET;
      rot_sin = '0;
      uv_pending.delete();
      errors_o = 0;
      n_checked = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (puv_pkg::cfg_reg_e'(cfg.index))
          puv_pkg::REG_MIN_X: box_lo[0] = cfg.data;
          puv_pkg::REG_MIN_Y: box_lo[1] = cfg.data;
          puv_pkg::REG_MIN_Z: box_lo[2] = cfg.data;
          puv_pkg::REG_MAX_X: box_hi[0] = cfg.data;
          puv_pkg::REG_MAX_Y: box_hi[1] = cfg.data;
          puv_pkg::REG_MAX_Z: box_hi[2] = cfg.data;
          puv_pkg::REG_COS:   rot_cos = cfg.data[puv_pkg::TRIG_W-1:0];
          puv_pkg::REG_SIN:   rot_sin = cfg.data[puv_pkg::TRIG_W-1:0];
          default: ;
        endcase
      end
      if (vtx.valid && vtx.ready)
        uv_pending.insert(uv_pending.size(),
                          project_vertex(vtx.pos_x, vtx.pos_y, vtx.pos_z));
      if (tex.valid && tex.ready) begin
        if (uv_pending.size() == 0) begin
          report_mismatch($sformatf("unexpected item u=%0d v=%0d", tex.tex_u, tex.tex_v));
        end else begin
          want = uv_pending.pop_front();
          if (tex.tex_u !== want.u)
            report_mismatch($sformatf("tex_u got %0d want %0d", tex.tex_u, want.u));
          if (tex.tex_v !== want.v)
            report_mismatch($sformatf("tex_v got %0d want %0d", tex.tex_v, want.v));
        end
        n_checked++;
      end
    end
  end

  function automatic int pending_count();
    return uv_pending.size();
  endfunction

endmodule

// File: tb/planar_uv_projection_core_tb.sv
// Top of the planar UV core testbench: clock, reset, stimulus, result stalls and verdict.
module planar_uv_projection_core_tb;

  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 64;

  logic clk_i;
  logic rst_ni;
  int   errors;
  int   n_sent;
  int   n_recv;
  int   n_cfg;
  bit   stall_out;
  bit   long_hold;

  puv_cfg_if cfg_bus ();
  puv_in_if  vtx_bus ();
  puv_out_if tex_bus ();

  planar_uv_projection_core u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .vtx_i (vtx_bus),
    .tex_o (tex_bus)
  );

  planar_uv_projection_core_checker u_checker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg     (cfg_bus),
    .vtx     (vtx_bus),
    .tex     (tex_bus),
    .errors_o(errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d of %0d results", cycles, n_recv, n_sent);
    $display("planar_uv_projection_core_tb: FAIL");
    $finish;
  end

  // Result side: random stall per item when stall_out is set, long hold-off on long_hold.
  initial begin
    int n;
    tex_bus.ready = 1'b0;
    n_recv = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        tex_bus.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
      end
      n = stall_out ? $urandom_range(0, 16) : 0;
      if (n > 0) begin
        tex_bus.ready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      tex_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(tex_bus.valid && tex_bus.ready));
      n_recv++;
      @(negedge clk_i);
    end
  end

  // Leaves valid high so that writes of one setup follow each other directly.
  task automatic write_reg(input puv_pkg::cfg_reg_e idx, input logic [31:0] value);
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    cfg_bus.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_bus.ready);
    n_cfg++;
    @(negedge clk_i);
  endtask

  task automatic load_setup(input logic [31:0] lo_x, input logic [31:0] lo_y,
                            input logic [31:0] lo_z, input logic [31:0] hi_x,
                            input logic [31:0] hi_y, input logic [31:0] hi_z,
                            input logic [15:0] c, input logic [15:0] s);
    write_reg(puv_pkg::REG_MIN_X, lo_x);
    write_reg(puv_pkg::REG_MIN_Y, lo_y);
    write_reg(puv_pkg::REG_MIN_Z, lo_z);
    write_reg(puv_pkg::REG_MAX_X, hi_x);
    write_reg(puv_pkg::REG_MAX_Y, hi_y);
    write_reg(puv_pkg::REG_MAX_Z, hi_z);
    write_reg(puv_pkg::REG_COS, {16'd0, c});
    write_reg(puv_pkg::REG_SIN, {16'd0, s});
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_vertex(input bit gaps, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
    int n;
    n = gaps ? $urandom_range(0, 16) : 0;
    if (n > 0) begin
      vtx_bus.valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    vtx_bus.pos_x <= x;
    vtx_bus.pos_y <= y;
    vtx_bus.pos_z <= z;
    vtx_bus.valid <= 1'b1;
    do @(posedge clk_i); while (!vtx_bus.ready);
    n_sent++;
    @(negedge clk_i);
  endtask

  // Stops offering vertices and waits until every result is back.
  task automatic drain();
    vtx_bus.valid <= 1'b0;
    while (n_recv != n_sent) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] in_range(input logic [31:0] lo, input logic [31:0] hi);
    longint l, h;
    l = $signed(lo);
    h = $signed(hi);
    if (h < l) begin
      l = h;
      h = $signed(lo);
    end
    return 32'(l + longint'({$urandom, $urandom} % 64'(h - l + 1)));
  endfunction

  function automatic logic [15:0] pick_trig(input int kind);
    case (kind)
      0: return 16'd16384;
      1: return 16'hC000;
      2: return 16'd0;
      3: return 16'(int'($urandom_range(0, 32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [31:0] lo [3];
    logic [31:0] hi [3];
    logic [31:0] p [3];
    logic [31:0] edges [6];
    bit          gaps;
    int          kind, span, mid;
    rst_ni = 1'b0;
    n_sent = 0;
    n_cfg = 0;
    stall_out = 1'b0;
    long_hold = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = puv_pkg::REG_MIN_X;
    cfg_bus.data = '0;
    vtx_bus.valid = 1'b0;
    vtx_bus.pos_x = '0;
    vtx_bus.pos_y = '0;
    vtx_bus.pos_z = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: reset setup with an all-zero box, then edge boxes and rotations.
    edges = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h00010000, 32'hFFFFFFFF, 32'h00008000};
    for (int i = 0; i < 4; i++) send_vertex(1'b0, edges[i], edges[i+1], edges[i+2]);
    drain();
    // Equal sizes everywhere, so the tie rule picks XZ.
    load_setup(0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 16'd16384, 16'd0);
    for (int i = 0; i < 4; i++) send_vertex(1'b0, edges[i], edges[5-i], edges[(i+3)%6]);
    drain();
    // Inverted Y zeroes the XY and YZ areas, so XZ is picked, with X thin.
    load_setup(0, 32'h20000, 0, 32'h100, 32'h10000, 32'h40000, 16'h4000, 16'hC000);
    for (int i = 0; i < 4; i++) send_vertex(1'b0, edges[i+2], edges[i], edges[5-i]);
    drain();
    // Box spanning the full range in X and Y, with trig patterns beyond unit magnitude.
    load_setup(32'h80000000, 32'h80000000, 32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h1,
               16'h7FFF, 16'h8000);
    for (int i = 0; i < 4; i++) send_vertex(1'b0, edges[i+1], edges[i+2], edges[i]);
    drain();
    load_setup(32'h7FFFFFFF, 0, 32'h7FFFFFFF, 32'h80000000, 32'h10, 32'h80000000,
               16'd0, 16'd16384);
    for (int i = 0; i < 4; i++) send_vertex(1'b0, edges[i], edges[i], edges[i]);
    drain();

    // Random phases, each with its own box shape, rotation and idling mix.
    for (int ph = 0; ph < 12; ph++) begin
      kind = $urandom_range(0, 5);
      for (int k = 0; k < 3; k++) begin
        span = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 32'h00400000);
        mid = $urandom;
        lo[k] = mid;
        hi[k] = 32'(longint'(mid) + span);
        if ($signed(hi[k]) < $signed(lo[k])) hi[k] = 32'h7FFFFFFF;
      end
      case (kind)
        1: begin
          lo = '{32'h80000000, 32'h80000000, 32'h80000000};
          hi = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
        end
        2: hi[$urandom_range(0, 2)] = lo[$urandom_range(0, 2)];
        3: begin
          p[0] = lo[1];
          lo[1] = hi[1];
          hi[1] = p[0];
        end
        4: for (int k = 0; k < 3; k++) hi[k] = lo[k] + 32'h10000;
        default: ;
      endcase
      load_setup(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2],
                 pick_trig($urandom_range(0, 4)), pick_trig($urandom_range(0, 4)));
      gaps = (ph % 4) != 1;
      stall_out = (ph % 4) != 2;
      if (ph == 3) long_hold = 1'b1;
      for (int i = 0; i < 90; i++) begin
        for (int k = 0; k < 3; k++)
          p[k] = ($urandom_range(0, 4) == 0) ? $urandom : in_range(lo[k], hi[k]);
        send_vertex(gaps, p[0], p[1], p[2]);
        if (ph == 5 && i == 45) drain();
      end
      drain();
    end

    while (u_checker.pending_count() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    $display("covered %0d vertices and %0d register writes over 17 setups", n_sent, n_cfg);
    $display("boxes: full range, inverted, degenerate and tied; rotations incl. odd patterns");
    if (errors == 0) begin
      $display("planar_uv_projection_core_tb: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("planar_uv_projection_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/puv_pkg.sv
rtl/core/puv_if.sv
rtl/core/puv_front.sv
rtl/core/puv_fifo.sv
rtl/core/puv_div.sv
rtl/core/puv_back.sv
rtl/core/planar_uv_projection_core.sv
tb/planar_uv_projection_core_checker.sv
tb/planar_uv_projection_core_tb.sv
